// ----- rtl/cca_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Contiguous cluster allocator package
// Shared codes and the sequencer state type.
// ----------------------------------------------------------------------------
package cca_pkg;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] STATUS_DONE   = 2'd0;
	localparam logic [1:0] STATUS_NO_FIT = 2'd1;
	localparam logic [1:0] STATUS_ERROR  = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FIT,
		ST_MARK,
		ST_FREE,
		ST_LONG,
		ST_PUSH
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/cca_run_track.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Free run tracker
// Follows the busy bits of a map scan and keeps the current and longest run.
// ----------------------------------------------------------------------------
module cca_run_track #(
	parameter int CW = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          clr,
	input  wire logic          upd,
	input  wire logic          busy,
	output logic [CW-1:0]      run_nxt,
	output logic [CW-1:0]      best
);

	logic [CW-1:0] run_q;
	logic [CW-1:0] best_q;

	assign run_nxt = busy ? '0 : run_q + CW'(1);
	assign best    = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= '0;
			best_q <= '0;
		end else if (clr) begin
			run_q  <= '0;
			best_q <= '0;
		end else if (upd) begin
			run_q <= run_nxt;
			if (run_nxt > best_q) begin
				best_q <= run_nxt;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/contiguous_cluster_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Contiguous cluster allocator
// First-fit allocation and release of cluster runs over a busy bit map.
// ----------------------------------------------------------------------------
// Sequence: an allocation runs a fit scan, marks the run when one fits, then a
// largest-run scan and a load of the result; a free clears its run, then the
// same scan and load. A zero length or bad free goes straight to the scan.
// Throughput: one request at a time, bounded by the single read port of the map.
// Reset: a clearing pass marks every cluster free;
// requests are held off until it ends, configuration writes are taken.
// ----------------------------------------------------------------------------
module contiguous_cluster_allocator #(
	parameter int MAX_CLUSTERS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [9:0]  start_cluster,
	input  wire logic [10:0] run_length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [9:0]       first_cluster,
	output logic [10:0]      largest_free_run,
	output logic [10:0]      busy_clusters
);

	localparam int AW = $clog2(MAX_CLUSTERS);
	localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;
	localparam logic [CW-1:0] MAX_CW = CW'(MAX_CLUSTERS);
	localparam logic [CW-1:0] LAST_CW = CW'(MAX_CLUSTERS - 1);

	cca_pkg::state_t state_q, state_d;

	logic [10:0]   cfg_q;
	logic [CW-1:0] n_cw;
	logic [CW-1:0] len_q;
	logic [CW-1:0] rd_k_q;
	logic [CW-1:0] end_q;
	logic [CW-1:0] busy_q;
	logic [CW-1:0] first_q;
	logic [1:0]    status_q;

	logic          map_mem [MAX_CLUSTERS];
	logic          rd_en, wr_en, wr_bit;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          rd_v_s1;
	logic          rd_bit_s1;
	logic [CW-1:0] rd_k_s1;

	logic          accept, push, out_take;
	logic          hit, trk_clr, trk_upd;
	logic [CW-1:0] run_nxt, best;
	logic [CW-1:0] in_len_cw;
	logic [CW:0]   free_end;
	logic          free_bad;
	logic [CW-1:0] fit_first;
	logic          scan_done, free_done, mark_last;

	logic          out_v_q;
	logic [1:0]    out_status_q;
	logic [9:0]    out_first_q;
	logic [10:0]   out_largest_q;
	logic [10:0]   out_busy_q;

	assign n_cw      = (CW'(cfg_q) > MAX_CW) ? MAX_CW : CW'(cfg_q);
	assign in_stall  = (state_q != cca_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_take  = out_v_q && !out_stall;
	assign push      = (state_q == cca_pkg::ST_PUSH) && (!out_v_q || !out_stall);
	assign in_len_cw = CW'(run_length);
	assign free_end  = (CW+1)'(start_cluster) + (CW+1)'(run_length);
	assign free_bad  = free_end > (CW+1)'(n_cw);
	assign fit_first = rd_k_s1 + CW'(1) - len_q;
	assign hit       = (state_q == cca_pkg::ST_FIT) && rd_v_s1 && (run_nxt == len_q);
	assign scan_done = (rd_k_q >= n_cw) && !rd_v_s1;
	assign free_done = (rd_k_q >= end_q) && !rd_v_s1;
	assign mark_last = (rd_k_q + CW'(1)) == end_q;
	assign trk_upd   = rd_v_s1 &&
		((state_q == cca_pkg::ST_FIT) || (state_q == cca_pkg::ST_LONG));
	assign trk_clr   = (state_d != state_q) &&
		((state_d == cca_pkg::ST_FIT) || (state_d == cca_pkg::ST_LONG));

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_bit  = 1'b0;
		rd_addr = rd_k_q[AW-1:0];
		wr_addr = rd_k_q[AW-1:0];
		unique case (state_q)
			cca_pkg::ST_INIT: begin
				wr_en = 1'b1;
				if (rd_k_q == LAST_CW) begin
					state_d = cca_pkg::ST_IDLE;
				end
			end
			cca_pkg::ST_IDLE: begin
				if (accept) begin
					if (run_length == 11'd0) begin
						state_d = cca_pkg::ST_LONG;
					end else if (func == cca_pkg::FUNC_ALLOC) begin
						state_d = cca_pkg::ST_FIT;
					end else if (free_bad) begin
						state_d = cca_pkg::ST_LONG;
					end else begin
						state_d = cca_pkg::ST_FREE;
					end
				end
			end
			cca_pkg::ST_FIT: begin
				rd_en = (rd_k_q < n_cw);
				if (hit) begin
					state_d = cca_pkg::ST_MARK;
				end else if (scan_done) begin
					state_d = cca_pkg::ST_LONG;
				end
			end
			cca_pkg::ST_MARK: begin
				wr_en  = 1'b1;
				wr_bit = 1'b1;
				if (mark_last) begin
					state_d = cca_pkg::ST_LONG;
				end
			end
			cca_pkg::ST_FREE: begin
				rd_en = (rd_k_q < end_q);
				wr_en = (rd_k_q < end_q);
				if (free_done) begin
					state_d = cca_pkg::ST_LONG;
				end
			end
			cca_pkg::ST_LONG: begin
				rd_en = (rd_k_q < n_cw);
				if (scan_done) begin
					state_d = cca_pkg::ST_PUSH;
				end
			end
			cca_pkg::ST_PUSH: begin
				if (push) begin
					state_d = cca_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cca_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cca_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 11'd1024;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_bit;
		end
		if (rd_en) begin
			rd_bit_s1 <= map_mem[rd_addr];
			rd_k_s1   <= rd_k_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
		end
	end

	cca_run_track #(
		.CW(CW)
	) u_run_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (trk_clr),
		.upd     (trk_upd),
		.busy    (rd_bit_s1),
		.run_nxt (run_nxt),
		.best    (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_k_q   <= '0;
			end_q    <= '0;
			busy_q   <= '0;
			len_q    <= '0;
			first_q  <= '0;
			status_q <= cca_pkg::STATUS_DONE;
		end else begin
			unique case (state_q)
				cca_pkg::ST_INIT: begin
					rd_k_q <= (rd_k_q == LAST_CW) ? '0 : rd_k_q + CW'(1);
				end
				cca_pkg::ST_IDLE: begin
					if (accept) begin
						len_q    <= in_len_cw;
						first_q  <= '0;
						status_q <= cca_pkg::STATUS_DONE;
						rd_k_q   <= '0;
						if (run_length == 11'd0) begin
							status_q <= cca_pkg::STATUS_ERROR;
						end else if (func == cca_pkg::FUNC_FREE) begin
							if (free_bad) begin
								status_q <= cca_pkg::STATUS_ERROR;
							end else begin
								rd_k_q <= CW'(start_cluster);
								end_q  <= free_end[CW-1:0];
							end
						end
					end
				end
				cca_pkg::ST_FIT: begin
					if (hit) begin
						first_q <= fit_first;
						rd_k_q  <= fit_first;
						end_q   <= rd_k_s1 + CW'(1);
					end else if (scan_done) begin
						status_q <= cca_pkg::STATUS_NO_FIT;
						rd_k_q   <= '0;
					end else if (rd_k_q < n_cw) begin
						rd_k_q <= rd_k_q + CW'(1);
					end
				end
				cca_pkg::ST_MARK: begin
					if (mark_last) begin
						busy_q <= busy_q + len_q;
						rd_k_q <= '0;
					end else begin
						rd_k_q <= rd_k_q + CW'(1);
					end
				end
				cca_pkg::ST_FREE: begin
					if (rd_v_s1 && rd_bit_s1 && (busy_q != '0)) begin
						busy_q <= busy_q - CW'(1);
					end
					if (free_done) begin
						rd_k_q <= '0;
					end else if (rd_k_q < end_q) begin
						rd_k_q <= rd_k_q + CW'(1);
					end
				end
				cca_pkg::ST_LONG: begin
					if (rd_k_q < n_cw) begin
						rd_k_q <= rd_k_q + CW'(1);
					end
				end
				cca_pkg::ST_PUSH: begin
					rd_k_q <= '0;
				end
				default: begin
					rd_k_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (out_take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_status_q  <= status_q;
			out_first_q   <= first_q[9:0];
			out_largest_q <= best[10:0];
			out_busy_q    <= busy_q[10:0];
		end
	end

	assign out_valid        = out_v_q;
	assign status           = out_status_q;
	assign first_cluster    = out_first_q;
	assign largest_free_run = out_largest_q;
	assign busy_clusters    = out_busy_q;

endmodule
`default_nettype wire
